[design/pctd_pkg.sv]
`timescale 1ns / 1ps

package pctd_pkg;

    localparam logic [7:0] PLUS_CHAR  = 8'h2B;
    localparam logic [7:0] SPACE_CHAR = 8'h20;
    localparam logic [7:0] PCT_CHAR   = 8'h25;
    localparam logic [7:0] NO_DIGIT   = 8'hFF;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       in_last;
    } in_word_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       out_last;
    } out_word_t;

    // One accepted input word turns into up to three output bytes.
    typedef struct packed {
        logic [1:0]      cnt;
        logic            last;
        logic [2:0][7:0] data;
    } cmd_t;

    typedef enum logic [1:0] {
        HOLD_NONE,
        HOLD_PCT,
        HOLD_DIGIT
    } hold_state_t;

    function automatic logic [7:0] digit_value(input logic [7:0] c);
        logic [7:0] v;
        v = NO_DIGIT;
        if (c >= 8'h30 && c <= 8'h39) begin
            v = c - 8'h30;
        end else if (c >= 8'h41 && c <= 8'h46) begin
            v = c - 8'h37;
        end else if (c >= 8'h61 && c <= 8'h66) begin
            v = c - 8'h57;
        end
        return v;
    endfunction

    function automatic logic is_hex(input logic [7:0] c);
        return digit_value(c) != NO_DIGIT;
    endfunction

    function automatic logic [3:0] hex_nibble(input logic [7:0] c);
        logic [7:0] v;
        v = digit_value(c);
        return v[3:0];
    endfunction

endpackage

[design/pctd_front.sv]
`timescale 1ns / 1ps

module pctd_front (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            enc_valid,
    output logic            enc_stall,
    input  pctd_pkg::in_word_t enc_word,
    input  logic            full,
    output logic            push,
    output pctd_pkg::cmd_t  cmd
);
    import pctd_pkg::*;

    hold_state_t state_reg;
    hold_state_t state_next;
    logic [7:0]  held_digit_reg;
    logic [7:0]  held_digit_next;
    logic [7:0]  b;
    logic        last;
    logic        fresh_hold;
    logic [7:0]  fresh_byte;
    logic        accept;

    assign b          = enc_word.in_byte;
    assign last       = enc_word.in_last;
    assign fresh_hold = (b == PCT_CHAR) && !last;
    assign fresh_byte = (b == PLUS_CHAR) ? SPACE_CHAR : b;
    assign enc_stall  = full;
    assign accept     = enc_valid && !full;

    always_comb
    begin
        cmd             = '0;
        state_next      = HOLD_NONE;
        held_digit_next = held_digit_reg;
        unique case (state_reg)
            HOLD_PCT:
            begin
                if (!last && is_hex(b)) begin
                    state_next      = HOLD_DIGIT;
                    held_digit_next = b;
                end else begin
                    cmd.data[0] = PCT_CHAR;
                    cmd.cnt     = 2'd1;
                    if (fresh_hold) begin
                        state_next = HOLD_PCT;
                    end else begin
                        cmd.data[1] = fresh_byte;
                        cmd.cnt     = 2'd2;
                    end
                end
            end
            HOLD_DIGIT:
            begin
                if (is_hex(b)) begin
                    cmd.data[0] = {hex_nibble(held_digit_reg), hex_nibble(b)};
                    cmd.cnt     = 2'd1;
                end else begin
                    // A broken escape releases the percent sign and the held digit.
                    cmd.data[0] = PCT_CHAR;
                    cmd.data[1] = held_digit_reg;
                    cmd.cnt     = 2'd2;
                    if (fresh_hold) begin
                        state_next = HOLD_PCT;
                    end else begin
                        cmd.data[2] = fresh_byte;
                        cmd.cnt     = 2'd3;
                    end
                end
            end
            default:
            begin
                if (fresh_hold) begin
                    state_next = HOLD_PCT;
                end else begin
                    cmd.data[0] = fresh_byte;
                    cmd.cnt     = 2'd1;
                end
            end
        endcase
        cmd.last = last;
        push     = accept && (cmd.cnt != 2'd0);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg      <= HOLD_NONE;
            held_digit_reg <= '0;
        end else if (accept) begin
            state_reg      <= state_next;
            held_digit_reg <= held_digit_next;
        end
    end

endmodule

[design/pctd_queue.sv]
`timescale 1ns / 1ps

module pctd_queue #(
    parameter int DEPTH = 4
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  pctd_pkg::cmd_t push_cmd,
    output logic           full,
    input  logic           pop,
    output pctd_pkg::cmd_t head,
    output logic           empty
);
    import pctd_pkg::*;

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [AW-1:0] LAST_PTR = AW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

    cmd_t          mem_reg [DEPTH];
    logic [AW-1:0] wr_ptr_reg;
    logic [AW-1:0] rd_ptr_reg;
    logic [CW-1:0] count_reg;
    logic [CW-1:0] count_next;
    logic          do_push;
    logic          do_pop;

    assign full    = (count_reg == FULL_CNT);
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign head    = mem_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (do_push && !do_pop) begin
            count_next = count_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            count_reg <= count_next;
            if (do_push) begin
                wr_ptr_reg <= (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (do_pop) begin
                rd_ptr_reg <= (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push) begin
            mem_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

[design/pctd_back.sv]
`timescale 1ns / 1ps

module pctd_back (
    input  logic               clk,
    input  logic               rst_n,
    input  pctd_pkg::cmd_t     head,
    input  logic               empty,
    output logic               pop,
    output logic               dec_valid,
    input  logic               dec_stall,
    output pctd_pkg::out_word_t dec_word
);
    import pctd_pkg::*;

    logic [1:0] idx_reg;
    logic [1:0] idx_next;
    logic       out_valid_reg;
    logic       out_valid_next;
    out_word_t  out_word_reg;
    out_word_t  out_word_next;
    logic       load;
    logic       final_byte;

    assign load       = !empty && (!out_valid_reg || !dec_stall);
    assign final_byte = (idx_reg == head.cnt - 2'd1);
    assign pop        = load && final_byte;
    assign dec_valid  = out_valid_reg;
    assign dec_word   = out_word_reg;

    always_comb
    begin
        idx_next                = idx_reg;
        out_valid_next          = out_valid_reg;
        out_word_next           = out_word_reg;
        if (load) begin
            out_valid_next         = 1'b1;
            out_word_next.out_byte = head.data[idx_reg];
            out_word_next.out_last = head.last && final_byte;
            idx_next               = final_byte ? 2'd0 : idx_reg + 2'd1;
        end else if (!dec_stall) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            idx_reg       <= 2'd0;
            out_valid_reg <= 1'b0;
        end else begin
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_word_reg <= out_word_next;
    end

endmodule

[design/percent_decoder_top.sv]
`timescale 1ns / 1ps

// Streaming URL percent decoder, with '+' read as a space.
// Input channel enc_*: one raw byte per word, in_last marking the final byte
// of a message. Output channel dec_*: one decoded byte per word, out_last set
// on the final decoded byte of each message. Both use valid/stall; a word
// moves on a rising edge with valid high and stall low.
// An input word is accepted every cycle while the command queue between the
// classifying front end and the output sequencer has room. Each input word
// yields zero to three output words; the output register issues one word per
// cycle unless stalled, so sustained throughput is one output word per cycle
// and the input rate follows the mix of results (one input per cycle for plain
// text). From an empty queue, a word's first result passes the queue memory
// and the output register. If dec_stall is held, the queue fills and enc_stall
// rises after QUEUE_DEPTH pending commands; the output word holds steady.
// Reset empties the queue, clears any held escape bytes and drops dec_valid.
module percent_decoder_top #(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                enc_valid,
    output logic                enc_stall,
    input  pctd_pkg::in_word_t  enc_word,
    output logic                dec_valid,
    input  logic                dec_stall,
    output pctd_pkg::out_word_t dec_word
);
    import pctd_pkg::*;

    cmd_t front_cmd;
    cmd_t head;
    logic push;
    logic pop;
    logic full;
    logic empty;

    pctd_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .enc_valid (enc_valid),
        .enc_stall (enc_stall),
        .enc_word  (enc_word),
        .full      (full),
        .push      (push),
        .cmd       (front_cmd)
    );

    pctd_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_cmd (front_cmd),
        .full     (full),
        .pop      (pop),
        .head     (head),
        .empty    (empty)
    );

    pctd_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .head      (head),
        .empty     (empty),
        .pop       (pop),
        .dec_valid (dec_valid),
        .dec_stall (dec_stall),
        .dec_word  (dec_word)
    );

endmodule

[design/pctd_checker.sv]
`timescale 1ns / 1ps

module pctd_checker (
    input logic                clk,
    input logic                rst_n,
    input logic                enc_stall,
    input logic                dec_valid,
    input logic                dec_stall,
    input pctd_pkg::out_word_t dec_word
);
    import pctd_pkg::*;

    // A stalled output word stays offered and unchanged.
    a_dec_hold: assert property (@(posedge clk) disable iff (!rst_n)
        dec_valid && dec_stall |=> dec_valid && $stable(dec_word))
        else $error("output word changed while stalled");

    a_reset_no_out: assert property (@(posedge clk)
        !rst_n |-> !dec_valid)
        else $error("output valid during reset");

    a_reset_no_stall: assert property (@(posedge clk)
        !rst_n |-> !enc_stall)
        else $error("input stalled during reset");

    // The input can only be held off when there is a backlog behind the output.
    a_stall_backlog: assert property (@(posedge clk) disable iff (!rst_n)
        enc_stall |-> dec_valid)
        else $error("input stalled with no output pending");

endmodule

bind percent_decoder_top pctd_checker u_pctd_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .enc_stall (enc_stall),
    .dec_valid (dec_valid),
    .dec_stall (dec_stall),
    .dec_word  (dec_word)
);

[sim/decode_checker.sv]
`timescale 1ns / 1ps

module decode_checker (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                enc_valid,
    input  logic                enc_stall,
    input  pctd_pkg::in_word_t  enc_word,
    input  logic                dec_valid,
    input  logic                dec_stall,
    input  pctd_pkg::out_word_t dec_word,
    output int                  mismatches,
    output int                  pending
);
    import pctd_pkg::*;

    out_word_t   decoded_q[$];
    hold_state_t held_state;
    logic [7:0]  held_digit;

    // Bit 4 says whether the byte is a hex digit; bits 3:0 carry its value.
    function automatic logic [4:0] hex_of(input logic [7:0] c);
        logic [4:0] r;
        r = 5'd0;
        if (c >= 8'h30 && c <= 8'h39) begin
            r = {1'b1, c[3:0]};
        end else if ((c >= 8'h41 && c <= 8'h46) || (c >= 8'h61 && c <= 8'h66)) begin
            r = {1'b1, c[3:0] + 4'd9};
        end
        return r;
    endfunction

    task automatic expect_byte(input logic [7:0] b, input logic l);
        out_word_t w;
        w = {b, l};
        decoded_q.push_back(w);
    endtask

    // A byte seen with nothing held in front of it.
    task automatic plain_byte(input logic [7:0] b, input logic l);
        if (b == PLUS_CHAR) begin
            expect_byte(SPACE_CHAR, l);
        end else if (b == PCT_CHAR && !l) begin
            held_state = HOLD_PCT;
        end else begin
            expect_byte(b, l);
        end
    endtask

    task automatic decode_word(input in_word_t w);
        hold_state_t was;
        logic [4:0]  hi;
        logic [4:0]  lo;
        was = held_state;
        held_state = HOLD_NONE;
        hi = hex_of(held_digit);
        lo = hex_of(w.in_byte);
        case (was)
            HOLD_PCT:
            begin
                if (!w.in_last && lo[4]) begin
                    held_digit = w.in_byte;
                    held_state = HOLD_DIGIT;
                end else begin
                    expect_byte(PCT_CHAR, 1'b0);
                    plain_byte(w.in_byte, w.in_last);
                end
            end
            HOLD_DIGIT:
            begin
                if (hi[4] && lo[4]) begin
                    expect_byte({hi[3:0], lo[3:0]}, w.in_last);
                end else begin
                    expect_byte(PCT_CHAR, 1'b0);
                    expect_byte(held_digit, 1'b0);
                    plain_byte(w.in_byte, w.in_last);
                end
            end
            default:
            begin
                plain_byte(w.in_byte, w.in_last);
            end
        endcase
        if (held_state == HOLD_NONE || w.in_last) begin
            held_state = HOLD_NONE;
            held_digit = 8'h00;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        out_word_t want;
        if (!rst_n) begin
            decoded_q.delete();
            held_state = HOLD_NONE;
            held_digit = 8'h00;
            mismatches <= 0;
            pending    <= 0;
        end else begin
            if (enc_valid && !enc_stall) begin
                decode_word(enc_word);
            end
            if (dec_valid && !dec_stall) begin
                if (decoded_q.size() == 0) begin
                    $display("%0t: unexpected word, actual byte %02h last %0b",
                             $time, dec_word.out_byte, dec_word.out_last);
                    mismatches <= mismatches + 1;
                end else begin
                    want = decoded_q.pop_front();
                    if (dec_word.out_byte !== want.out_byte) begin
                        $display("%0t: byte mismatch, expected %02h actual %02h",
                                 $time, want.out_byte, dec_word.out_byte);
                        mismatches <= mismatches + 1;
                    end else if (dec_word.out_last !== want.out_last) begin
                        $display("%0t: last flag mismatch, expected %0b actual %0b",
                                 $time, want.out_last, dec_word.out_last);
                        mismatches <= mismatches + 1;
                    end
                end
            end
            pending <= decoded_q.size();
        end
    end

endmodule

[sim/tb.sv]
`timescale 1ns / 1ps

module tb;
    import pctd_pkg::*;

    typedef logic [7:0] byte_q_t[$];

    localparam int RANDOM_WORDS = 225;
    localparam int HOLD_CYCLES  = 120;
    localparam int IDLE_LIMIT   = 2000;

    logic      clk;
    logic      rst_n;
    logic      enc_valid;
    logic      enc_stall;
    in_word_t  enc_word;
    logic      dec_valid;
    logic      dec_stall;
    out_word_t dec_word;
    int        mismatches;
    int        pending;
    int        idle_cycles;
    logic      gaps_on;
    logic      hold_req;

    percent_decoder_top u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .enc_valid (enc_valid),
        .enc_stall (enc_stall),
        .enc_word  (enc_word),
        .dec_valid (dec_valid),
        .dec_stall (dec_stall),
        .dec_word  (dec_word)
    );

    decode_checker u_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .enc_valid  (enc_valid),
        .enc_stall  (enc_stall),
        .enc_word   (enc_word),
        .dec_valid  (dec_valid),
        .dec_stall  (dec_stall),
        .dec_word   (dec_word),
        .mismatches (mismatches),
        .pending    (pending)
    );

    always
    begin
        clk = 1'b1;
        #2;
        clk = 1'b0;
        #2;
    end

    // Any cycle without a handshake on either side counts towards the limit.
    always @(posedge clk)
    begin
        if ((enc_valid && !enc_stall) || (dec_valid && !dec_stall)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("percent_decoder_top regression: fail");
            $finish;
        end
    end

    // Receiver: random stalls, plus a long hold-off on each request.
    initial
    begin
        dec_stall <= 1'b0;
        forever begin
            @(posedge clk);
            if (hold_req) begin
                hold_req = 1'b0;
                dec_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge clk);
            end else begin
                dec_stall <= gaps_on && ($urandom_range(99) < 19);
            end
        end
    end

    task automatic send_word(input logic [7:0] b, input logic l);
        while (gaps_on && $urandom_range(99) < 19) begin
            enc_valid <= 1'b0;
            @(posedge clk);
        end
        enc_valid <= 1'b1;
        enc_word  <= {b, l};
        @(posedge clk);
        while (enc_stall) @(posedge clk);
    endtask

    task automatic send_message(input byte_q_t msg);
        for (int i = 0; i < msg.size(); i++) begin
            send_word(msg[i], i == msg.size() - 1);
        end
    endtask

    function automatic logic [7:0] any_hex();
        int n;
        n = $urandom_range(21);
        if (n < 10) begin
            return 8'(8'h30 + n);
        end else if (n < 16) begin
            return 8'(8'h41 + n - 10);
        end
        return 8'(8'h61 + n - 16);
    endfunction

    // Mostly well-formed escapes with random content, plus signs, lone hex digits,
    // random bytes, some stray '%' and bytes just outside the hex ranges to break sequences.
    function automatic byte_q_t random_message();
        byte_q_t    msg;
        logic [7:0] edges_q[$];
        int         len;
        int         r;
        edges_q = '{8'h2F, 8'h3A, 8'h40, 8'h47, 8'h60, 8'h67};
        len = $urandom_range(1, 10);
        while (msg.size() < len) begin
            r = $urandom_range(99);
            if (r < 30) begin
                msg.push_back(PCT_CHAR);
                msg.push_back(any_hex());
                msg.push_back(any_hex());
            end else if (r < 40) begin
                msg.push_back(PLUS_CHAR);
            end else if (r < 50) begin
                msg.push_back(PCT_CHAR);
            end else if (r < 60) begin
                msg.push_back(any_hex());
            end else if (r < 70) begin
                msg.push_back(edges_q[$urandom_range(edges_q.size() - 1)]);
            end else begin
                msg.push_back(8'($urandom_range(255)));
            end
        end
        return msg;
    endfunction

    initial
    begin
        byte_q_t msg;
        int      sent;
        rst_n     = 1'b0;
        enc_valid <= 1'b0;
        enc_word  <= '0;
        gaps_on   = 1'b1;
        hold_req  = 1'b0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Extreme byte values.
        send_message('{8'h00, 8'hFF});
        // Plus, then an escape closing on the last byte.
        send_message('{PLUS_CHAR, PCT_CHAR, 8'h34, 8'h31});
        // Mixed-case escape, then a message ending on a bare percent.
        send_message('{PCT_CHAR, 8'h66, 8'h46, PCT_CHAR});
        // Non-hex after percent, and a non-hex second digit that is a plus.
        send_message('{PCT_CHAR, 8'h47, PCT_CHAR, 8'h34, PLUS_CHAR});
        // Message ending one byte after a percent, on a hex digit.
        send_message('{PCT_CHAR, 8'h34});
        // Percent after percent opens a fresh escape.
        send_message('{PCT_CHAR, PCT_CHAR, 8'h32, 8'h62});
        send_message('{PCT_CHAR});
        send_message('{PCT_CHAR, 8'h30, 8'h30});

        // Let the pipeline drain completely before the random part.
        enc_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);

        sent = 0;
        while (sent < RANDOM_WORDS) begin
            if (sent >= 60 && sent < 75) begin
                hold_req = 1'b1;
            end
            gaps_on = !(sent >= 120 && sent < 190);
            msg = random_message();
            send_message(msg);
            sent += msg.size();
        end
        gaps_on = 1'b1;
        enc_valid <= 1'b0;

        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (20) @(posedge clk);
        if (mismatches == 0 && pending == 0) begin
            $display("percent_decoder_top regression: pass");
        end else begin
            $display("percent_decoder_top regression: fail");
        end
        $finish;
    end

endmodule
